>>> design/rme_pkg.sv
// Shared constants and types for the rotation matrix to Euler angle pipeline.
package rme_pkg;

    localparam int MW      = 16;  // matrix element width
    localparam int CW      = 27;  // CORDIC x/y datapath width
    localparam int ZW      = 20;  // CORDIC angle width, 2^-16 rad
    localparam int NW      = 46;  // square root work width
    localparam int SQ      = 23;  // square root steps
    localparam int TAB_LEN = 24;
    localparam int NU      = 5;   // parallel CORDIC units
    localparam int PW      = 42;  // degree product width
    localparam int OW      = 16;  // output angle width
    localparam int TW      = 13;  // lock threshold width

    localparam logic signed [ZW-1:0] HALF_PI   = 20'sd102944;
    localparam logic signed [PW-1:0] DEG_SCALE = 42'sd1877468;
    localparam logic signed [PW-1:0] DEG_ROUND = 42'sd8388608;
    localparam logic signed [17:0]   DEG_LIMIT = 18'sd23040;
    localparam logic [TW-1:0]        THR_RESET = 13'd66;

    localparam logic [16:0] ATAN_TAB [0:TAB_LEN-1] = '{
        17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
        17'd256,   17'd128,   17'd64,    17'd32,   17'd16,   17'd8,    17'd4,    17'd2,
        17'd1,     17'd0,     17'd0,     17'd0,    17'd0,    17'd0,    17'd0,    17'd0
    };

    // CORDIC unit assignment
    localparam int U_ROLL  = 0;
    localparam int U_YAW   = 1;
    localparam int U_PITCH = 2;
    localparam int U_LOCKP = 3;
    localparam int U_LOCKM = 4;

    typedef enum logic [1:0] {
        LOCK_NONE = 2'd0,
        LOCK_POS  = 2'd1,
        LOCK_NEG  = 2'd2
    } lock_t;

endpackage

>>> design/rotation_matrix_to_euler.sv
// Rotation matrix to roll/pitch/yaw: clamp, pipelined square root, five CORDICs, degrees.
// CORDIC_STAGES is capped at 24.
// Throughput: one item per cycle; the whole pipeline holds while the output item waits.
// Stages: input, square, radicand, 23 square root steps, pre-rotation, CORDIC steps, lock, scale, output.
// Reset (aresetn low, synchronous): pipeline empties, lock_threshold returns to 66.
module rotation_matrix_to_euler #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [15:0]      s_m00,
    input  logic signed [15:0]      s_m02,
    input  logic signed [15:0]      s_m10,
    input  logic signed [15:0]      s_m12,
    input  logic signed [15:0]      s_m20,
    input  logic signed [15:0]      s_m21,
    input  logic signed [15:0]      s_m22,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [15:0]      m_roll_deg,
    output logic signed [15:0]      m_pitch_deg,
    output logic signed [15:0]      m_yaw_deg,
    output logic [1:0]              m_lock_case,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [12:0]             cfg_data
);

    localparam int NS = (CORDIC_STAGES > rme_pkg::TAB_LEN) ? rme_pkg::TAB_LEN : CORDIC_STAGES;
    localparam int MW = rme_pkg::MW;
    localparam int CW = rme_pkg::CW;
    localparam int ZW = rme_pkg::ZW;
    localparam int NW = rme_pkg::NW;
    localparam int SQ = rme_pkg::SQ;
    localparam int NU = rme_pkg::NU;
    localparam int PW = rme_pkg::PW;

    logic en;
    logic [rme_pkg::TW-1:0] thr_reg;

    assign en        = !m_valid || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= rme_pkg::THR_RESET;
        end else if (cfg_valid) begin
            thr_reg <= cfg_data;
        end
    end

    // input stage
    logic in_vld_reg;
    logic signed [MW-1:0] in_m_reg [0:6];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (en) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_m_reg[0] <= s_m00;
            in_m_reg[1] <= s_m02;
            in_m_reg[2] <= s_m10;
            in_m_reg[3] <= s_m12;
            in_m_reg[4] <= s_m20;
            in_m_reg[5] <= s_m21;
            in_m_reg[6] <= s_m22;
        end
    end

    // clamp s = -m20 to [-1, 1] and square it
    logic signed [MW:0]   neg_m20;
    logic signed [MW-1:0] s_next;

    always_comb begin
        neg_m20 = -{in_m_reg[4][MW-1], in_m_reg[4]};
        if (neg_m20 > 17'sd16384) begin
            s_next = 16'sd16384;
        end else if (neg_m20 < -17'sd16384) begin
            s_next = -16'sd16384;
        end else begin
            s_next = neg_m20[MW-1:0];
        end
    end

    logic sq_vld_reg;
    logic [28:0] sq_reg;
    logic signed [MW-1:0] sq_s_reg;
    logic signed [MW-1:0] sq_m_reg [0:5];
    logic signed [2*MW-1:0] sq_full;

    assign sq_full = s_next * s_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg <= 1'b0;
        end else if (en) begin
            sq_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg      <= sq_full[28:0];
            sq_s_reg    <= s_next;
            sq_m_reg[0] <= in_m_reg[0];
            sq_m_reg[1] <= in_m_reg[1];
            sq_m_reg[2] <= in_m_reg[2];
            sq_m_reg[3] <= in_m_reg[3];
            sq_m_reg[4] <= in_m_reg[5];
            sq_m_reg[5] <= in_m_reg[6];
        end
    end

    // square root pipeline, one result bit per stage
    logic                 rt_vld_reg [0:SQ];
    logic [NW-1:0]        rt_n_reg   [0:SQ];
    logic [NW-1:0]        rt_r_reg   [0:SQ];
    logic signed [MW-1:0] rt_s_reg   [0:SQ];
    logic signed [MW-1:0] rt_m_reg   [0:SQ][0:5];
    logic [29:0]          rad_next;

    assign rad_next = 30'(30'd268435456 - 30'(sq_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rt_vld_reg[0] <= 1'b0;
        end else if (en) begin
            rt_vld_reg[0] <= sq_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rt_n_reg[0] <= NW'(rad_next) << 16;
            rt_r_reg[0] <= '0;
            rt_s_reg[0] <= sq_s_reg;
            for (int j = 0; j < 6; j++) begin
                rt_m_reg[0][j] <= sq_m_reg[j];
            end
        end
    end

    for (genvar k = 0; k < SQ; k++) begin : g_sqrt
        localparam logic [NW-1:0] BIT = NW'(1) << (2 * (SQ - 1 - k));
        logic [NW-1:0] trial;

        assign trial = rt_r_reg[k] + BIT;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rt_vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                rt_vld_reg[k+1] <= rt_vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rt_n_reg[k] >= trial) begin
                    rt_n_reg[k+1] <= rt_n_reg[k] - trial;
                    rt_r_reg[k+1] <= (rt_r_reg[k] >> 1) + BIT;
                end else begin
                    rt_n_reg[k+1] <= rt_n_reg[k];
                    rt_r_reg[k+1] <= rt_r_reg[k] >> 1;
                end
                rt_s_reg[k+1] <= rt_s_reg[k];
                for (int j = 0; j < 6; j++) begin
                    rt_m_reg[k+1][j] <= rt_m_reg[k][j];
                end
            end
        end
    end

    // CORDIC operands
    logic signed [CW-1:0] op_y [0:NU-1];
    logic signed [CW-1:0] op_x [0:NU-1];

    always_comb begin
        op_y[rme_pkg::U_ROLL]  = CW'(rt_m_reg[SQ][4]) <<< 8;
        op_x[rme_pkg::U_ROLL]  = CW'(rt_m_reg[SQ][5]) <<< 8;
        op_y[rme_pkg::U_YAW]   = CW'(rt_m_reg[SQ][2]) <<< 8;
        op_x[rme_pkg::U_YAW]   = CW'(rt_m_reg[SQ][0]) <<< 8;
        op_y[rme_pkg::U_PITCH] = CW'(rt_s_reg[SQ]) <<< 8;
        op_x[rme_pkg::U_PITCH] = $signed({1'b0, rt_r_reg[SQ][CW-2:0]});
        op_y[rme_pkg::U_LOCKP] = CW'(rt_m_reg[SQ][3]) <<< 8;
        op_x[rme_pkg::U_LOCKP] = CW'(rt_m_reg[SQ][1]) <<< 8;
        op_y[rme_pkg::U_LOCKM] = -(CW'(rt_m_reg[SQ][3]) <<< 8);
        op_x[rme_pkg::U_LOCKM] = -(CW'(rt_m_reg[SQ][1]) <<< 8);
    end

    // CORDIC pre-rotation and stages
    logic                 cv_reg [0:NS];
    logic signed [CW-1:0] cx_reg [0:NS][0:NU-1];
    logic signed [CW-1:0] cy_reg [0:NS][0:NU-1];
    logic signed [ZW-1:0] cz_reg [0:NS][0:NU-1];
    logic                 cf_reg [0:NS][0:NU-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg[0] <= 1'b0;
        end else if (en) begin
            cv_reg[0] <= rt_vld_reg[SQ];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int u = 0; u < NU; u++) begin
                cf_reg[0][u] <= (op_x[u] == '0) && (op_y[u] == '0);
                if (op_x[u] < 0) begin
                    if (op_y[u] >= 0) begin
                        cx_reg[0][u] <= op_y[u];
                        cy_reg[0][u] <= -op_x[u];
                        cz_reg[0][u] <= rme_pkg::HALF_PI;
                    end else begin
                        cx_reg[0][u] <= -op_y[u];
                        cy_reg[0][u] <= op_x[u];
                        cz_reg[0][u] <= -rme_pkg::HALF_PI;
                    end
                end else begin
                    cx_reg[0][u] <= op_x[u];
                    cy_reg[0][u] <= op_y[u];
                    cz_reg[0][u] <= '0;
                end
            end
        end
    end

    for (genvar i = 0; i < NS; i++) begin : g_cordic
        localparam logic signed [ZW-1:0] ANG = ZW'(rme_pkg::ATAN_TAB[i]);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cv_reg[i+1] <= 1'b0;
            end else if (en) begin
                cv_reg[i+1] <= cv_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int u = 0; u < NU; u++) begin
                    cf_reg[i+1][u] <= cf_reg[i][u];
                    if (cy_reg[i][u] >= 0) begin
                        cx_reg[i+1][u] <= cx_reg[i][u] + (cy_reg[i][u] >>> i);
                        cy_reg[i+1][u] <= cy_reg[i][u] - (cx_reg[i][u] >>> i);
                        cz_reg[i+1][u] <= cz_reg[i][u] + ANG;
                    end else begin
                        cx_reg[i+1][u] <= cx_reg[i][u] - (cy_reg[i][u] >>> i);
                        cy_reg[i+1][u] <= cy_reg[i][u] + (cx_reg[i][u] >>> i);
                        cz_reg[i+1][u] <= cz_reg[i][u] - ANG;
                    end
                end
            end
        end
    end

    logic signed [ZW-1:0] ang [0:NU-1];

    always_comb begin
        for (int u = 0; u < NU; u++) begin
            ang[u] = cf_reg[NS][u] ? '0 : cz_reg[NS][u];
        end
    end

    // gimbal lock selection
    logic signed [ZW:0] dp_next;
    logic signed [ZW:0] dm_next;
    logic               near_pos;
    logic               near_neg;

    always_comb begin
        dp_next = (ZW+1)'(ang[rme_pkg::U_PITCH]) - (ZW+1)'(rme_pkg::HALF_PI);
        dm_next = (ZW+1)'(ang[rme_pkg::U_PITCH]) + (ZW+1)'(rme_pkg::HALF_PI);
        if (dp_next < 0) begin
            dp_next = -dp_next;
        end
        if (dm_next < 0) begin
            dm_next = -dm_next;
        end
        near_pos = dp_next < $signed({8'd0, thr_reg});
        near_neg = dm_next < $signed({8'd0, thr_reg});
    end

    logic                 lk_vld_reg;
    logic signed [ZW-1:0] lk_roll_reg;
    logic signed [ZW-1:0] lk_pitch_reg;
    logic signed [ZW-1:0] lk_yaw_reg;
    rme_pkg::lock_t       lk_case_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lk_vld_reg <= 1'b0;
        end else if (en) begin
            lk_vld_reg <= cv_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lk_yaw_reg <= ang[rme_pkg::U_YAW];
            if (near_pos) begin
                lk_roll_reg  <= '0;
                lk_pitch_reg <= ang[rme_pkg::U_LOCKP];
                lk_case_reg  <= rme_pkg::LOCK_POS;
            end else if (near_neg) begin
                lk_roll_reg  <= '0;
                lk_pitch_reg <= ang[rme_pkg::U_LOCKM];
                lk_case_reg  <= rme_pkg::LOCK_NEG;
            end else begin
                lk_roll_reg  <= ang[rme_pkg::U_ROLL];
                lk_pitch_reg <= ang[rme_pkg::U_PITCH];
                lk_case_reg  <= rme_pkg::LOCK_NONE;
            end
        end
    end

    // scale to 1/128 degree
    logic                 ml_vld_reg;
    logic signed [PW-1:0] ml_roll_reg;
    logic signed [PW-1:0] ml_pitch_reg;
    logic signed [PW-1:0] ml_yaw_reg;
    rme_pkg::lock_t       ml_case_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ml_vld_reg <= 1'b0;
        end else if (en) begin
            ml_vld_reg <= lk_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ml_roll_reg  <= PW'(lk_roll_reg) * rme_pkg::DEG_SCALE;
            ml_pitch_reg <= PW'(lk_pitch_reg) * rme_pkg::DEG_SCALE;
            ml_yaw_reg   <= PW'(lk_yaw_reg) * rme_pkg::DEG_SCALE;
            ml_case_reg  <= lk_case_reg;
        end
    end

    function automatic logic signed [15:0] to_deg(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] t;
        logic signed [17:0]   d;
        t = (p + rme_pkg::DEG_ROUND) >>> 24;
        d = t[17:0];
        if (d > rme_pkg::DEG_LIMIT) begin
            d = rme_pkg::DEG_LIMIT;
        end else if (d < -rme_pkg::DEG_LIMIT) begin
            d = -rme_pkg::DEG_LIMIT;
        end
        return d[15:0];
    endfunction

    logic m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= ml_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_roll_deg  <= to_deg(ml_roll_reg);
            m_pitch_deg <= to_deg(ml_pitch_reg);
            m_yaw_deg   <= to_deg(ml_yaw_reg);
            m_lock_case <= ml_case_reg;
        end
    end

    assign m_valid = m_valid_reg;

endmodule
